/* hw/rtl/wfd_pkg.sv */
package wfd_pkg;

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [7:0] OP_TEXT_FINAL   = 8'h81;
    localparam logic [7:0] OP_BINARY_FINAL = 8'h82;
    localparam logic [6:0] LEN_MASK        = 7'h7f;
    localparam logic [6:0] LEN_EXT16       = 7'd126;
    localparam logic [6:0] LEN_EXT64       = 7'd127;

    localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0] MASK_BYTES_M1  = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_binary;
        logic       last_byte;
        logic       empty_frame;
        logic       aborted;
    } pl_item_t;

endpackage

/* hw/rtl/websocket_frame_deframer_top.sv */
// WebSocket frame deframer: takes one stream byte per transfer on rx and gives
// one unmasked payload byte per transfer on pl, plus single status transfers for
// empty frames (empty_frame) and frames abandoned by a restart (aborted). Only
// final text (0x81) and final binary (0x82) frames are taken; after a bad first
// byte, input is dropped until a chunk start carries a valid first byte. One byte
// is accepted every cycle while rx_stall is low; its result, if any, is registered.
// The header decode, 64-bit length count and key XOR are all combinational
// between the byte transfer and the result register (or skid); a two-entry
// output stage (result register plus skid) keeps rx running while pl stalls, and
// rx_stall rises only while the skid entry is held.
module websocket_frame_deframer_top
    import wfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rx_valid,
    output logic     rx_stall,
    input  rx_item_t rx_data,
    output logic     pl_valid,
    input  logic     pl_stall,
    output pl_item_t pl_data
);

    logic [2:0]  phase_reg, phase_next;
    logic        discarding_reg, discarding_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic        mask_present_reg, mask_present_next;
    logic [1:0]  mask_phase_reg, mask_phase_next;
    logic        frame_binary_reg, frame_binary_next;

    logic        out_valid_reg;
    pl_item_t    out_data_reg;
    logic        skid_valid_reg;
    pl_item_t    skid_data_reg;

    logic        accept;
    logic        res_valid;
    pl_item_t    res;
    logic [7:0]  b;
    logic        cs;
    logic        op_ok;
    logic [6:0]  len7;
    logic [63:0] ext_len;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;

    assign accept = rx_valid && !rx_stall;
    assign b      = rx_data.data_byte;
    assign cs     = rx_data.chunk_start;
    assign op_ok  = (b == OP_TEXT_FINAL) || (b == OP_BINARY_FINAL);
    assign len7   = b[6:0] & LEN_MASK;
    assign ext_len  = {remaining_reg[55:0], b};
    assign rem_dec  = remaining_reg - 64'd1;
    assign key_byte = 8'(mask_key_reg >> {~mask_phase_reg, 3'b000});

    always_comb
    begin
        phase_next        = phase_reg;
        discarding_next   = discarding_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        mask_present_next = mask_present_reg;
        mask_phase_next   = mask_phase_reg;
        frame_binary_next = frame_binary_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.is_binary     = frame_binary_reg;

        if (discarding_reg || phase_reg == PH_OPCODE || (cs && op_ok))
        begin
            if (op_ok && (cs || !discarding_reg))
            begin
                if (!discarding_reg && phase_reg != PH_OPCODE)
                begin
                    res_valid   = 1'b1;
                    res.aborted = 1'b1;
                end
                frame_binary_next = (b == OP_BINARY_FINAL);
                phase_next        = PH_LENGTH;
                discarding_next   = 1'b0;
                hdr_cnt_next      = '0;
                remaining_next    = '0;
                mask_key_next     = '0;
                mask_present_next = 1'b0;
                mask_phase_next   = '0;
            end
            else if (!discarding_reg)
            begin
                discarding_next = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    mask_present_next = b[7];
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64)
                    begin
                        remaining_next = '0;
                        hdr_cnt_next   = (len7 == LEN_EXT16) ? EXT16_BYTES_M1 : EXT64_BYTES_M1;
                        phase_next     = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = {57'd0, len7};
                        if (b[7])
                        begin
                            phase_next    = PH_MASK;
                            hdr_cnt_next  = MASK_BYTES_M1;
                            mask_key_next = '0;
                        end
                        else
                        begin
                            mask_phase_next = '0;
                            hdr_cnt_next    = '0;
                            if (len7 == 7'd0)
                            begin
                                phase_next      = PH_OPCODE;
                                res_valid       = 1'b1;
                                res.empty_frame = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    remaining_next = ext_len;
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        if (mask_present_reg)
                        begin
                            phase_next    = PH_MASK;
                            hdr_cnt_next  = MASK_BYTES_M1;
                            mask_key_next = '0;
                        end
                        else
                        begin
                            mask_phase_next = '0;
                            if (ext_len == 64'd0)
                            begin
                                phase_next      = PH_OPCODE;
                                res_valid       = 1'b1;
                                res.empty_frame = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg - 3'd1;
                    end
                end
                PH_MASK:
                begin
                    mask_key_next = {mask_key_reg[23:0], b};
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        mask_phase_next = '0;
                        if (remaining_reg == 64'd0)
                        begin
                            phase_next      = PH_OPCODE;
                            res_valid       = 1'b1;
                            res.empty_frame = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg - 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_phase_next  = mask_phase_reg + 2'd1;
                    remaining_next   = rem_dec;
                    res_valid        = 1'b1;
                    res.payload_byte = mask_present_reg ? (b ^ key_byte) : b;
                    if (rem_dec == 64'd0)
                    begin
                        phase_next    = PH_OPCODE;
                        res.last_byte = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OPCODE;
            discarding_reg   <= 1'b0;
            hdr_cnt_reg      <= '0;
            remaining_reg    <= '0;
            mask_key_reg     <= '0;
            mask_present_reg <= 1'b0;
            mask_phase_reg   <= '0;
            frame_binary_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            discarding_reg   <= discarding_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            mask_present_reg <= mask_present_next;
            mask_phase_reg   <= mask_phase_next;
            frame_binary_reg <= frame_binary_next;
        end
    end

    // result register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !pl_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept && res_valid;
            end
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !pl_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (accept && res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign rx_stall = skid_valid_reg;
    assign pl_valid = out_valid_reg;
    assign pl_data  = out_data_reg;

endmodule

/* hw/rtl/wfd_checker.sv */
module wfd_checker
    import wfd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rx_valid,
    input logic     rx_stall,
    input rx_item_t rx_data,
    input logic     pl_valid,
    input logic     pl_stall,
    input pl_item_t pl_data
);

    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_data))
        else $error("rx transfer changed while stalled");

    a_pl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pl_valid && pl_stall |=> pl_valid && $stable(pl_data))
        else $error("pl transfer changed while stalled");

    a_rose_after_rx: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pl_valid) |-> $past(rx_valid && !rx_stall))
        else $error("result without rx transfer");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pl_valid && (pl_data.aborted || pl_data.empty_frame) |->
            pl_data.payload_byte == 8'd0 && !pl_data.last_byte)
        else $error("status transfer carries payload");

    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        pl_valid |-> !(pl_data.aborted && pl_data.empty_frame))
        else $error("aborted and empty_frame together");

endmodule

bind websocket_frame_deframer_top wfd_checker u_wfd_checker (.*);

/* tb/deframe_check_pkg.sv */
`timescale 1ns / 100ps

package deframe_check_pkg;

    import wfd_pkg::*;

    class deframe_scoreboard;

        logic [2:0]  phase      = PH_OPCODE;
        bit          discarding = 1'b0;
        logic [2:0]  hdr_left   = '0;
        logic [63:0] remaining  = '0;
        logic [31:0] key        = '0;
        bit          masked     = 1'b0;
        logic [1:0]  key_idx    = '0;
        bit          binary     = 1'b0;

        pl_item_t    expected_out_q[$];
        int unsigned failures = 0;

        function int pending();
            return expected_out_q.size();
        endfunction

        function void open_frame(logic [7:0] b);
            binary     = (b == OP_BINARY_FINAL);
            phase      = PH_LENGTH;
            discarding = 1'b0;
            hdr_left   = '0;
            remaining  = '0;
            key        = '0;
            masked     = 1'b0;
            key_idx    = '0;
        endfunction

        function void push_result(logic [7:0] pay, bit last, bit empty, bit abrt);
            pl_item_t r;
            r.payload_byte = pay;
            r.is_binary    = binary;
            r.last_byte    = last;
            r.empty_frame  = empty;
            r.aborted      = abrt;
            expected_out_q.push_back(r);
        endfunction

        function void close_header();
            key_idx  = '0;
            hdr_left = '0;
            if (remaining == 64'd0)
            begin
                phase = PH_OPCODE;
                push_result(8'h00, 1'b0, 1'b1, 1'b0);
            end
            else
            begin
                phase = PH_PAYLOAD;
            end
        endfunction

        function void length_complete();
            if (masked)
            begin
                phase    = PH_MASK;
                hdr_left = MASK_BYTES_M1;
                key      = '0;
            end
            else
            begin
                close_header();
            end
        endfunction

        // Returns 0 when the byte is dropped while hunting for a frame start.
        function bit note_byte(rx_item_t it);
            logic [7:0] b;
            logic [6:0] len7;
            bit         cs;
            bit         opener;
            b      = it.data_byte;
            cs     = it.chunk_start;
            opener = (b == OP_TEXT_FINAL) || (b == OP_BINARY_FINAL);
            if (discarding)
            begin
                if (cs && opener)
                begin
                    open_frame(b);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (phase == PH_OPCODE)
            begin
                if (opener)
                    open_frame(b);
                else
                    discarding = 1'b1;
                return 1'b1;
            end
            if (cs && opener)
            begin
                push_result(8'h00, 1'b0, 1'b0, 1'b1);
                open_frame(b);
                return 1'b1;
            end
            case (phase)
                PH_LENGTH:
                begin
                    masked    = b[7];
                    len7      = b[6:0] & LEN_MASK;
                    remaining = '0;
                    if (len7 == LEN_EXT16)
                    begin
                        hdr_left = EXT16_BYTES_M1;
                        phase    = PH_EXTLEN;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        hdr_left = EXT64_BYTES_M1;
                        phase    = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining = 64'(len7);
                        length_complete();
                    end
                end
                PH_EXTLEN:
                begin
                    remaining = {remaining[55:0], b};
                    if (hdr_left == 3'd0)
                        length_complete();
                    else
                        hdr_left--;
                end
                PH_MASK:
                begin
                    key = {key[23:0], b};
                    if (hdr_left == 3'd0)
                        close_header();
                    else
                        hdr_left--;
                end
                PH_PAYLOAD:
                begin
                    if (masked)
                        b = b ^ key[8 * (3 - key_idx) +: 8];
                    key_idx++;
                    remaining--;
                    if (remaining == 64'd0)
                    begin
                        phase = PH_OPCODE;
                        push_result(b, 1'b1, 1'b0, 1'b0);
                    end
                    else
                    begin
                        push_result(b, 1'b0, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    phase = PH_OPCODE;
                end
            endcase
            return 1'b1;
        endfunction

        function void check_payload(pl_item_t got);
            pl_item_t want;
            if (expected_out_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pl transfer: byte %h bin %b last %b empty %b abort %b",
                             got.payload_byte, got.is_binary, got.last_byte,
                             got.empty_frame, got.aborted);
                return;
            end
            want = expected_out_q.pop_front();
            if (got.payload_byte !== want.payload_byte || got.is_binary !== want.is_binary ||
                got.last_byte !== want.last_byte || got.empty_frame !== want.empty_frame ||
                got.aborted !== want.aborted)
            begin
                failures++;
                if (failures <= 10)
                    $display("pl mismatch (byte/bin/last/empty/abort): got %h/%b/%b/%b/%b %s",
                             got.payload_byte, got.is_binary, got.last_byte,
                             got.empty_frame, got.aborted,
                             $sformatf("want %h/%b/%b/%b/%b", want.payload_byte,
                                       want.is_binary, want.last_byte,
                                       want.empty_frame, want.aborted));
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import wfd_pkg::*;
    import deframe_check_pkg::*;

    localparam int unsigned ITEMS      = 1950;
    localparam int unsigned CALM_START = 1750;
    localparam int unsigned LIMIT      = 500000;

    logic     clk;
    logic     rst_n;
    logic     rx_valid;
    logic     rx_stall;
    rx_item_t rx_data;
    logic     pl_valid;
    logic     pl_stall;
    pl_item_t pl_data;

    deframe_scoreboard sb = new;

    int unsigned taken_cnt   = 0;
    int unsigned cycle_cnt   = 0;
    bit          held_long   = 1'b0;
    bit          paused_once = 1'b0;

    websocket_frame_deframer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_data  (rx_data),
        .pl_valid (pl_valid),
        .pl_stall (pl_stall),
        .pl_data  (pl_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pl_valid && !pl_stall)
            sb.check_payload(pl_data);
    end

    // quiet window mid-run and no idling at the tail
    function automatic bit idling_on();
        return taken_cnt < CALM_START && (taken_cnt < 400 || taken_cnt >= 550);
    endfunction

    initial
    begin
        pl_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_long && taken_cnt >= 700)
            begin
                held_long = 1'b1;
                pl_stall <= 1'b1;
                repeat (120) @(posedge clk);
                pl_stall <= 1'b0;
            end
            else if (idling_on() && $urandom_range(0, 7) == 0)
            begin
                pl_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                pl_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic cs);
        rx_item_t item;
        item = '{value, cs};
        if (idling_on() && $urandom_range(0, 5) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= item;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        if (sb.note_byte(item))
            taken_cnt++;
    endtask

    task automatic send_random_frame();
        rx_item_t    q[$];
        logic [63:0] len;
        bit          masked;
        int unsigned form;
        int unsigned body;
        int unsigned keep;
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 6))
                q.push_back(rx_item_t'{8'($urandom), 1'($urandom)});
        q.push_back(rx_item_t'{($urandom_range(0, 1) != 0) ? OP_BINARY_FINAL : OP_TEXT_FINAL,
                               $urandom_range(0, 9) != 0});
        masked = 1'($urandom);
        form   = $urandom_range(0, 19);
        if (form < 13)
        begin
            len = (form == 0) ? 64'($urandom_range(0, 125)) : 64'($urandom_range(0, 20));
            q.push_back(rx_item_t'{{masked, len[6:0]}, 1'b0});
        end
        else if (form < 17)
        begin
            len = (form == 13) ? 64'($urandom_range(0, 300)) : 64'($urandom_range(0, 40));
            q.push_back(rx_item_t'{{masked, LEN_EXT16}, 1'b0});
            q.push_back(rx_item_t'{len[15:8], 1'b0});
            q.push_back(rx_item_t'{len[7:0], 1'b0});
        end
        else
        begin
            // huge random lengths never finish; the next frame start aborts them
            len = (form == 19) ? {$urandom, $urandom} : 64'($urandom_range(0, 30));
            q.push_back(rx_item_t'{{masked, LEN_EXT64}, 1'b0});
            for (int i = 7; i >= 0; i--)
                q.push_back(rx_item_t'{len[8 * i +: 8], 1'b0});
        end
        if (masked)
            repeat (4) q.push_back(rx_item_t'{8'($urandom), 1'b0});
        body = (len > 64'd300) ? $urandom_range(0, 12) : int'(len);
        repeat (body)
            q.push_back(rx_item_t'{8'($urandom), $urandom_range(0, 15) == 0});
        if ($urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, q.size());
            while (q.size() > keep) void'(q.pop_back());
        end
        foreach (q[i])
            send_byte(q[i].data_byte, q[i].chunk_start);
    endtask

    initial
    begin
        rx_valid <= 1'b0;
        rx_data  <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // empty binary frame
        send_byte(OP_BINARY_FINAL, 1'b1);
        send_byte({1'b0, 7'd0}, 1'b0);
        // masked text frame, 16-bit length; opcode value and chunk start as payload
        send_byte(OP_TEXT_FINAL, 1'b1);
        send_byte({1'b1, LEN_EXT16}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(OP_TEXT_FINAL, 1'b0);
        send_byte(8'h00, 1'b1);
        // 64-bit length with top bit set, unmasked, aborted in payload
        send_byte(OP_TEXT_FINAL, 1'b1);
        send_byte({1'b0, LEN_EXT64}, 1'b0);
        send_byte(8'h80, 1'b0);
        repeat (7) send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(OP_BINARY_FINAL, 1'b1);
        // abort inside the mask key, then empty text frame
        send_byte({1'b1, 7'd1}, 1'b0);
        send_byte(OP_TEXT_FINAL, 1'b1);
        send_byte(8'h00, 1'b0);
        // bad first byte, opcode without chunk start ignored, then recovery
        send_byte(8'h00, 1'b1);
        send_byte(OP_BINARY_FINAL, 1'b0);
        send_byte(OP_BINARY_FINAL, 1'b1);
        send_byte({1'b0, 7'd1}, 1'b0);
        send_byte(8'h5a, 1'b0);

        while (taken_cnt < ITEMS)
        begin
            if (!paused_once && taken_cnt >= 1200)
            begin
                paused_once = 1'b1;
                rx_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            send_random_frame();
        end
        rx_valid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
